### design/prc_pkg.sv
// Shared constants, types and the quarter-wave sine table of the PR current controller.
package prc_pkg;

    localparam int PWM_PERIOD       = 2000;
    localparam int SINE_DEPTH       = 1024;
    localparam int ADC_BITS         = 12;

    localparam int ADC_MID          = 2512;
    localparam int IG_SCALE         = 321655;
    localparam int DAMP             = 1073911383;
    localparam int PHASE_DIV        = 360;
    localparam int PHASE_BIAS       = 180 + 360 * (1 << 20);

    localparam int S_A1             = 1686629713;
    localparam int S_A3             = 693598668;
    localparam int S_A5             = 85569306;
    localparam int S_A7             = 5026996;
    localparam int S_A9             = 172272;

    localparam int SIN_AW           = $clog2(SINE_DEPTH);
    localparam int IDX_W            = SIN_AW + 2;
    localparam int ROM_AW           = SIN_AW + 1;

    localparam int MUL_W            = 32;
    localparam int PROD_W           = 64;
    localparam int MUL_CNT_W        = $clog2(MUL_W);

    localparam int DIV_NUM_W        = 29;
    localparam int DIV_DEN_W        = 13;
    localparam int DIV_CNT_W        = $clog2(DIV_NUM_W);

    localparam logic [2:0] CFG_REF_AMPLITUDE  = 3'd0;
    localparam logic [2:0] CFG_PHASE_OFFSET   = 3'd1;
    localparam logic [2:0] CFG_PROP_GAIN      = 3'd2;
    localparam logic [2:0] CFG_RES_GAIN       = 3'd3;
    localparam logic [2:0] CFG_OUTPUT_DIVISOR = 3'd4;
    localparam logic [2:0] CFG_RELAY_ENABLE   = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_IG,
        ST_PHASE,
        ST_ROM,
        ST_IREF,
        ST_C2,
        ST_T0,
        ST_T1,
        ST_T2,
        ST_T3,
        ST_LIMIT,
        ST_DUTY,
        ST_FINISH
    } ctl_state_t;

    typedef struct packed {
        logic                     start;
        logic signed [MUL_W-1:0]  mcand;
        logic signed [MUL_W-1:0]  mplier;
    } mul_req_t;

    typedef struct packed {
        logic                  start;
        logic [DIV_NUM_W-1:0]  num;
        logic [DIV_DEN_W-1:0]  den;
    } div_req_t;

    typedef logic [14:0] sine_rom_t [0:SINE_DEPTH];

    function automatic longint rshr(longint a, int s);
        return (a + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t t;
        longint    x;
        longint    x2;
        longint    p;
        longint    s;
        for (int k = 0; k <= SINE_DEPTH; k++)
        begin
            x  = (longint'(k) * (longint'(1) <<< 30)) / SINE_DEPTH;
            x2 = rshr(x * x, 30);
            p  = longint'(S_A9);
            p  = -longint'(S_A7) + rshr(p * x2, 30);
            p  = longint'(S_A5) + rshr(p * x2, 30);
            p  = -longint'(S_A3) + rshr(p * x2, 30);
            p  = longint'(S_A1) + rshr(p * x2, 30);
            s  = rshr(p * x, 45);
            if (s < 0)
            begin
                s = 0;
            end
            if (s > 32767)
            begin
                s = 32767;
            end
            t[k] = s[14:0];
        end
        return t;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

### design/prc_serial_mul.sv
// Bit-serial signed shift-add multiplier, one multiplier bit per cycle.
module prc_serial_mul
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  prc_pkg::mul_req_t                     req,
    output logic                                  done,
    output logic signed [prc_pkg::PROD_W-1:0]     product
);

    logic                                  busy_reg;
    logic                                  done_reg;
    logic [prc_pkg::MUL_CNT_W-1:0]         cnt_reg;
    logic signed [prc_pkg::PROD_W-1:0]     mcand_reg;
    logic [prc_pkg::MUL_W-1:0]             mplier_reg;
    logic signed [prc_pkg::PROD_W-1:0]     prod_reg;

    logic                                  last;
    logic signed [prc_pkg::PROD_W-1:0]     addend;
    logic signed [prc_pkg::PROD_W-1:0]     prod_next;

    always_comb
    begin
        last      = (cnt_reg == prc_pkg::MUL_CNT_W'(prc_pkg::MUL_W - 1));
        addend    = mplier_reg[0] ? mcand_reg : '0;
        prod_next = last ? (prod_reg - addend) : (prod_reg + addend);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            mcand_reg  <= prc_pkg::PROD_W'(req.mcand);
            mplier_reg <= req.mplier;
            prod_reg   <= '0;
        end
        else if (busy_reg)
        begin
            mcand_reg  <= mcand_reg <<< 1;
            mplier_reg <= mplier_reg >> 1;
            prod_reg   <= prod_next;
        end
    end

    assign done    = done_reg;
    assign product = prod_reg;

endmodule

### design/prc_serial_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module prc_serial_div
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  prc_pkg::div_req_t                   req,
    output logic                                done,
    output logic [prc_pkg::DIV_NUM_W-1:0]       quotient,
    output logic                                rem_nonzero
);

    logic                                busy_reg;
    logic                                done_reg;
    logic [prc_pkg::DIV_CNT_W-1:0]       cnt_reg;
    logic [prc_pkg::DIV_NUM_W-1:0]       num_reg;
    logic [prc_pkg::DIV_DEN_W-1:0]       den_reg;
    logic [prc_pkg::DIV_DEN_W-1:0]       rem_reg;

    logic                                last;
    logic [prc_pkg::DIV_DEN_W:0]         trial;
    logic                                fits;
    logic [prc_pkg::DIV_DEN_W:0]         diff;
    logic [prc_pkg::DIV_DEN_W-1:0]       rem_next;

    always_comb
    begin
        last     = (cnt_reg == prc_pkg::DIV_CNT_W'(prc_pkg::DIV_NUM_W - 1));
        trial    = {rem_reg, num_reg[prc_pkg::DIV_NUM_W-1]};
        fits     = (trial >= {1'b0, den_reg});
        diff     = trial - {1'b0, den_reg};
        rem_next = fits ? diff[prc_pkg::DIV_DEN_W-1:0] : trial[prc_pkg::DIV_DEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[prc_pkg::DIV_NUM_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign done        = done_reg;
    assign quotient    = num_reg;
    assign rem_nonzero = (rem_reg != '0);

endmodule

### design/prc_sine_rom.sv
// Quarter-wave sine table with registered read data.
module prc_sine_rom
(
    input  logic                            clk,
    input  logic [prc_pkg::ROM_AW-1:0]      addr,
    output logic [14:0]                     data
);

    logic [14:0] data_reg;

    always_ff @(posedge clk)
    begin
        data_reg <= prc_pkg::SINE_ROM[addr];
    end

    assign data = data_reg;

endmodule

### design/pr_current_controller_pwm_unit.sv
// Top level of the proportional-resonant grid current controller with PWM compare outputs.
//
//  channel  handshake               payload
//  s_axis   s_axis_tvalid/tready    s_axis_tdata: current_code, grid_angle, grid_sine
//  m_axis   m_axis_tvalid/tready    m_axis_tdata: relay_on, compares, duty, reference
//  cfg      cfg_valid/cfg_ready     cfg_index, cfg_data
//
// Each request is worked through before the next is accepted: seven 32-bit
// products on the bit-serial multiplier, two 29-bit quotients on the
// bit-serial divider and four further steps; the duty quotient is
// skipped when the duty leaves plus or minus one.
// Reset clears the equation state, the relay and the configuration to defaults.
// A finished result waits in the output register; the next request is taken meanwhile
// and stalls only at its last step until the output register is free.
module pr_current_controller_pwm_unit
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,   // current_code[11:0], grid_angle[27:12], grid_sine[43:28]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [87:0]  m_axis_tdata,   // relay_on[0], low_leg_compare[11:1],
                                         // leg_a_compare[22:12], leg_b_compare[34:23],
                                         // duty_value[50:35], current_reference[82:51]
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    prc_pkg::ctl_state_t state_reg;
    prc_pkg::ctl_state_t state_next;
    logic                launched_reg;
    logic                launched_next;

    logic [15:0]         amp_reg;
    logic signed [8:0]   deg_reg;
    logic [15:0]         kp_reg;
    logic [15:0]         krts_reg;
    logic [11:0]         odiv_reg;
    logic                relay_en_reg;

    logic signed [31:0]  err1_reg;
    logic signed [31:0]  err2_reg;
    logic signed [31:0]  out1_reg;
    logic signed [31:0]  out2_reg;
    logic signed [15:0]  prev_duty_reg;
    logic                prev_pos_reg;
    logic                relay_state_reg;
    logic                engaged_reg;

    logic [prc_pkg::ADC_BITS-1:0] code_reg;
    logic [15:0]         angle_reg;
    logic                relay_out_reg;
    logic signed [23:0]  ig_reg;
    logic signed [31:0]  iref_reg;
    logic signed [31:0]  e0_reg;
    logic signed [31:0]  c2_reg;
    logic signed [63:0]  acc_reg;
    logic [prc_pkg::ROM_AW-1:0] rom_addr_reg;
    logic                sneg_reg;
    logic [prc_pkg::DIV_NUM_W-1:0] dnum_reg;
    logic                dneg_reg;
    logic signed [17:0]  duty_reg;

    logic                out_valid_reg;
    logic                o_relay_reg;
    logic [10:0]         o_low_reg;
    logic [10:0]         o_a_reg;
    logic [11:0]         o_b_reg;
    logic [15:0]         o_duty_reg;
    logic [31:0]         o_ref_reg;

    prc_pkg::mul_req_t   mul_req;
    logic                mul_done;
    logic signed [63:0]  mul_product;
    prc_pkg::div_req_t   div_req;
    logic                div_done;
    logic [prc_pkg::DIV_NUM_W-1:0] div_quotient;
    logic                div_rem_nz;
    logic [14:0]         rom_data;

    logic                in_fire;
    logic                out_fire;
    logic                out_free;
    logic                engage;
    logic signed [15:0]  in_sine;

    logic signed [prc_pkg::ADC_BITS:0] code_diff;
    logic signed [31:0]  kp_full;
    logic signed [31:0]  c1;
    logic signed [31:0]  phase_sum;
    logic [15:0]         tot;
    logic [prc_pkg::IDX_W-1:0]  idx;
    logic [1:0]          quad;
    logic [prc_pkg::ROM_AW-1:0] rem_addr;
    logic [prc_pkg::ROM_AW-1:0] rom_addr;
    logic signed [15:0]  sine_val;

    logic signed [63:0]  prod_r8;
    logic signed [63:0]  prod_r7;
    logic signed [63:0]  prod_r30;
    logic signed [63:0]  prod_r14;
    logic signed [31:0]  iref_val;

    logic signed [63:0]  acc_sh;
    logic signed [31:0]  out0;
    logic [11:0]         divv;
    logic signed [33:0]  out0_w;
    logic signed [33:0]  lim_w;
    logic                over;
    logic signed [33:0]  a_w;
    logic signed [33:0]  a_mag;
    logic signed [17:0]  q_s;
    logic signed [17:0]  duty_val;

    logic signed [18:0]  diff_w;
    logic                slew;
    logic signed [17:0]  dsel;
    logic                pos;
    logic signed [17:0]  wrap;
    logic [39:0]         pwm_prod;
    logic [24:0]         braw;
    logic [24:0]         a_raw;
    logic [24:0]         cmp_a;
    logic [24:0]         cmp_b;
    logic [15:0]         dsat;

    prc_serial_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .done    (mul_done),
        .product (mul_product)
    );

    prc_serial_div u_div
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (div_req),
        .done        (div_done),
        .quotient    (div_quotient),
        .rem_nonzero (div_rem_nz)
    );

    prc_sine_rom u_rom
    (
        .clk  (clk),
        .addr (rom_addr_reg),
        .data (rom_data)
    );

    assign s_axis_tready = (state_reg == prc_pkg::ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = out_valid_reg && m_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign in_sine       = $signed(s_axis_tdata[43:28]);
    assign engage        = prev_pos_reg && in_sine[15] && relay_en_reg;

    always_comb
    begin
        code_diff = $signed({1'b0, code_reg}) - (prc_pkg::ADC_BITS + 1)'(prc_pkg::ADC_MID);
        kp_full   = $signed({8'b0, kp_reg, 8'b0});
        c1        = $signed({16'b0, krts_reg}) - (kp_full <<< 1);
        phase_sum = $signed({{7{deg_reg[8]}}, deg_reg, 16'b0}) + 32'(prc_pkg::PHASE_BIAS);
        tot       = angle_reg + div_quotient[15:0];
        idx       = tot[15 -: prc_pkg::IDX_W];
        quad      = idx[prc_pkg::IDX_W-1 -: 2];
        rem_addr  = {1'b0, idx[prc_pkg::SIN_AW-1:0]};
        rom_addr  = quad[0] ? (prc_pkg::ROM_AW'(prc_pkg::SINE_DEPTH) - rem_addr) : rem_addr;
        sine_val  = sneg_reg ? -$signed({1'b0, rom_data}) : $signed({1'b0, rom_data});

        prod_r8   = mul_product + 64'sd128;
        prod_r7   = mul_product + 64'sd64;
        prod_r30  = mul_product + (64'sd1 <<< 30 >>> 1);
        prod_r14  = (mul_product + 64'sd8192) >>> 14;
        iref_val  = prod_r7[38:7];

        acc_sh    = (acc_reg + 64'sd32768) >>> 16;
        if (acc_sh > 64'sd2147483647)
        begin
            out0 = 32'sh7fffffff;
        end
        else if (acc_sh < -64'sd2147483648)
        begin
            out0 = 32'sh80000000;
        end
        else
        begin
            out0 = acc_sh[31:0];
        end
        divv   = (odiv_reg == '0) ? 12'd1 : odiv_reg;
        out0_w = 34'(out0);
        lim_w  = $signed({6'b0, divv, 16'b0});
        over   = (out0_w > lim_w) || (out0_w < -lim_w);
        a_w    = out0_w + $signed({22'b0, divv});
        a_mag  = a_w[33] ? -a_w : a_w;
        q_s    = $signed({1'b0, div_quotient[16:0]});
        duty_val = dneg_reg ? (-q_s - $signed({17'b0, div_rem_nz})) : q_s;

        diff_w = 19'(duty_reg) - 19'(prev_duty_reg);
        slew   = (diff_w > 19'sd65536) || (diff_w < -19'sd65536);
        dsel   = slew ? 18'(prev_duty_reg) : duty_reg;
        pos    = (dsel > 18'sd0);
        wrap   = pos ? dsel : (dsel + 18'sd32768);
        pwm_prod = 40'(wrap[16:0]) * 40'(2 * prc_pkg::PWM_PERIOD);
        braw   = pwm_prod[39:15];
        cmp_b  = (braw > 25'(2 * prc_pkg::PWM_PERIOD)) ? 25'(2 * prc_pkg::PWM_PERIOD) : braw;
        a_raw  = braw - 25'(prc_pkg::PWM_PERIOD);
        if (braw < 25'(prc_pkg::PWM_PERIOD))
        begin
            cmp_a = '0;
        end
        else if (a_raw > 25'(prc_pkg::PWM_PERIOD))
        begin
            cmp_a = 25'(prc_pkg::PWM_PERIOD);
        end
        else
        begin
            cmp_a = a_raw;
        end
        dsat = (wrap > 18'sd32767) ? 16'h7fff : wrap[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= prc_pkg::ST_IDLE;
            launched_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            launched_reg <= launched_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mul_req    = '0;
        div_req    = '0;
        unique case (state_reg)
            prc_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = prc_pkg::ST_IG;
                end
            end
            prc_pkg::ST_IG:
            begin
                mul_req.mcand  = 32'(prc_pkg::IG_SCALE);
                mul_req.mplier = 32'(code_diff);
                if (mul_done)
                begin
                    state_next = prc_pkg::ST_PHASE;
                end
            end
            prc_pkg::ST_PHASE:
            begin
                div_req.num = phase_sum[prc_pkg::DIV_NUM_W-1:0];
                div_req.den = prc_pkg::DIV_DEN_W'(prc_pkg::PHASE_DIV);
                if (div_done)
                begin
                    state_next = prc_pkg::ST_ROM;
                end
            end
            prc_pkg::ST_ROM:
            begin
                state_next = prc_pkg::ST_IREF;
            end
            prc_pkg::ST_IREF:
            begin
                mul_req.mcand  = $signed({16'b0, amp_reg});
                mul_req.mplier = 32'(sine_val);
                if (mul_done)
                begin
                    state_next = prc_pkg::ST_C2;
                end
            end
            prc_pkg::ST_C2:
            begin
                mul_req.mcand  = 32'(prc_pkg::DAMP);
                mul_req.mplier = kp_full;
                if (mul_done)
                begin
                    state_next = prc_pkg::ST_T0;
                end
            end
            prc_pkg::ST_T0:
            begin
                mul_req.mcand  = kp_full;
                mul_req.mplier = e0_reg;
                if (mul_done)
                begin
                    state_next = prc_pkg::ST_T1;
                end
            end
            prc_pkg::ST_T1:
            begin
                mul_req.mcand  = c1;
                mul_req.mplier = err1_reg;
                if (mul_done)
                begin
                    state_next = prc_pkg::ST_T2;
                end
            end
            prc_pkg::ST_T2:
            begin
                mul_req.mcand  = c2_reg;
                mul_req.mplier = err2_reg;
                if (mul_done)
                begin
                    state_next = prc_pkg::ST_T3;
                end
            end
            prc_pkg::ST_T3:
            begin
                mul_req.mcand  = 32'(prc_pkg::DAMP);
                mul_req.mplier = out2_reg;
                if (mul_done)
                begin
                    state_next = prc_pkg::ST_LIMIT;
                end
            end
            prc_pkg::ST_LIMIT:
            begin
                state_next = over ? prc_pkg::ST_FINISH : prc_pkg::ST_DUTY;
            end
            prc_pkg::ST_DUTY:
            begin
                div_req.num = dnum_reg;
                div_req.den = {divv, 1'b0};
                if (div_done)
                begin
                    state_next = prc_pkg::ST_FINISH;
                end
            end
            prc_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = prc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = prc_pkg::ST_IDLE;
            end
        endcase
        mul_req.start = !launched_reg && (state_reg == prc_pkg::ST_IG
                        || state_reg == prc_pkg::ST_IREF || state_reg == prc_pkg::ST_C2
                        || state_reg == prc_pkg::ST_T0 || state_reg == prc_pkg::ST_T1
                        || state_reg == prc_pkg::ST_T2 || state_reg == prc_pkg::ST_T3);
        div_req.start = !launched_reg && (state_reg == prc_pkg::ST_PHASE
                        || state_reg == prc_pkg::ST_DUTY);
        launched_next = (state_next == state_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_reg         <= 16'd256;
            deg_reg         <= '0;
            kp_reg          <= 16'd1280;
            krts_reg        <= 16'd5243;
            odiv_reg        <= 12'd400;
            relay_en_reg    <= 1'b0;
            err1_reg        <= '0;
            err2_reg        <= '0;
            out1_reg        <= '0;
            out2_reg        <= '0;
            prev_duty_reg   <= '0;
            prev_pos_reg    <= 1'b0;
            relay_state_reg <= 1'b0;
            engaged_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    prc_pkg::CFG_REF_AMPLITUDE:  amp_reg      <= cfg_data;
                    prc_pkg::CFG_PHASE_OFFSET:   deg_reg      <= $signed(cfg_data[8:0]);
                    prc_pkg::CFG_PROP_GAIN:      kp_reg       <= cfg_data;
                    prc_pkg::CFG_RES_GAIN:       krts_reg     <= cfg_data;
                    prc_pkg::CFG_OUTPUT_DIVISOR: odiv_reg     <= cfg_data[11:0];
                    prc_pkg::CFG_RELAY_ENABLE:   relay_en_reg <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
            if (in_fire)
            begin
                prev_pos_reg <= !in_sine[15] && (in_sine != '0);
                if (!relay_en_reg)
                begin
                    relay_state_reg <= 1'b0;
                    engaged_reg     <= 1'b0;
                end
                else if (engage)
                begin
                    relay_state_reg <= 1'b1;
                    engaged_reg     <= 1'b1;
                    if (!engaged_reg)
                    begin
                        err1_reg <= '0;
                        err2_reg <= '0;
                        out1_reg <= '0;
                        out2_reg <= '0;
                    end
                end
            end
            if (state_reg == prc_pkg::ST_LIMIT)
            begin
                if (over)
                begin
                    err1_reg <= '0;
                    err2_reg <= '0;
                    out1_reg <= '0;
                    out2_reg <= '0;
                end
                else
                begin
                    err2_reg <= err1_reg;
                    err1_reg <= e0_reg;
                    out2_reg <= out1_reg;
                    out1_reg <= out0;
                end
            end
            if (state_reg == prc_pkg::ST_FINISH && out_free)
            begin
                prev_duty_reg <= $signed(dsat);
                out_valid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            code_reg      <= s_axis_tdata[prc_pkg::ADC_BITS-1:0];
            angle_reg     <= s_axis_tdata[27:12];
            relay_out_reg <= relay_state_reg;
        end
        if (state_reg == prc_pkg::ST_IG && mul_done)
        begin
            ig_reg <= prod_r8[31:8];
        end
        if (state_reg == prc_pkg::ST_PHASE && div_done)
        begin
            rom_addr_reg <= rom_addr;
            sneg_reg     <= quad[1];
        end
        if (state_reg == prc_pkg::ST_IREF && mul_done)
        begin
            iref_reg <= iref_val;
            e0_reg   <= iref_val - 32'(ig_reg);
        end
        if (state_reg == prc_pkg::ST_C2 && mul_done)
        begin
            c2_reg <= prod_r30[61:30] - $signed({16'b0, krts_reg});
        end
        if (state_reg == prc_pkg::ST_T0 && mul_done)
        begin
            acc_reg <= mul_product;
        end
        if ((state_reg == prc_pkg::ST_T1 || state_reg == prc_pkg::ST_T2) && mul_done)
        begin
            acc_reg <= acc_reg + mul_product;
        end
        if (state_reg == prc_pkg::ST_T3 && mul_done)
        begin
            acc_reg <= acc_reg + (64'(out1_reg) <<< 17) - prod_r14;
        end
        if (state_reg == prc_pkg::ST_LIMIT)
        begin
            dnum_reg <= a_mag[prc_pkg::DIV_NUM_W-1:0];
            dneg_reg <= a_w[33];
            if (over)
            begin
                duty_reg <= '0;
            end
        end
        if (state_reg == prc_pkg::ST_DUTY && div_done)
        begin
            duty_reg <= duty_val;
        end
        if (state_reg == prc_pkg::ST_FINISH && out_free)
        begin
            o_relay_reg <= relay_out_reg;
            o_low_reg   <= pos ? 11'd0 : 11'(prc_pkg::PWM_PERIOD);
            o_a_reg     <= cmp_a[10:0];
            o_b_reg     <= cmp_b[11:0];
            o_duty_reg  <= dsat;
            o_ref_reg   <= iref_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, o_ref_reg, o_duty_reg, o_b_reg, o_a_reg, o_low_reg,
                            o_relay_reg};

`ifndef SYNTHESIS
    relay_pair_chk: assert property (@(posedge clk) disable iff (!rst_n)
        relay_state_reg == engaged_reg)
        else $error("relay state and engagement flag disagree");

    start_chk: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg != prc_pkg::ST_IDLE)
        else $error("request accepted without starting work");

    duty_sign_chk: assert property (@(posedge clk) disable iff (!rst_n)
        !prev_duty_reg[15])
        else $error("stored duty went negative after wrap");

    single_unit_chk: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_req.start && div_req.start))
        else $error("multiplier and divider launched together");
`endif

endmodule
